>>> hw/rtl/cel_pkg.sv
// ----------------------------------------------------------------------------
// Circular event log package
// Shared sizes, command codes and the read-status bundle for the log ring.
// ----------------------------------------------------------------------------
`default_nettype none

package cel_pkg;

  // Ring geometry.
  localparam int MAX_ENTRIES = 256;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int SIZE_W      = $clog2(MAX_ENTRIES + 1);

  // Field widths fixed by the interface.
  localparam int KIND_W  = 2;
  localparam int CYCLE_W = 32;
  localparam int TIME_W  = 24;
  localparam int CODE_W  = 8;
  localparam int IDX_W   = 8;
  localparam int CFG_W   = 9;
  localparam int ENTRY_W = CYCLE_W + TIME_W + CODE_W;

  // Width of the oldest-plus-index sum before wrapping.
  localparam int SUM_W = ((SIZE_W > IDX_W) ? SIZE_W : IDX_W) + 1;

  // Reset value of the ring size register.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  // Command codes.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Status of a read transfer, aligned with the registered memory data.
  typedef struct packed {
    logic strobe;
    logic err;
    logic full;
    logic hit;
  } rd_info_t;

  // Effective ring size: zero acts as one, large values saturate.
  function automatic logic [SIZE_W-1:0] ring_size(input logic [CFG_W-1:0] cfg);
    logic [SIZE_W-1:0] n;
    n = SIZE_W'(MAX_ENTRIES);
    if (cfg == '0) begin
      n = SIZE_W'(1);
    end else if (int'(cfg) <= MAX_ENTRIES) begin
      n = SIZE_W'(cfg);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cel_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle at a shared address, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cel_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/cel_ctrl.sv
// ----------------------------------------------------------------------------
// Circular event log control
// Ring pointers, full flag, per-slot valid bits and memory address generation.
// ----------------------------------------------------------------------------
`default_nettype none

module cel_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic [cel_pkg::KIND_W-1:0]   kind,
  input  wire logic [cel_pkg::IDX_W-1:0]    read_index,
  input  wire logic                         cfg_we,
  input  wire logic [cel_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                              mem_we,
  output logic      [cel_pkg::SLOT_W-1:0]   mem_addr,
  output cel_pkg::rd_info_t                 rd_info,
  output logic                              full_flag
);

  logic [cel_pkg::CFG_W-1:0]       entries_in_use;
  logic [cel_pkg::SLOT_W-1:0]      next_slot;
  logic [cel_pkg::SLOT_W-1:0]      oldest_slot;
  logic [cel_pkg::MAX_ENTRIES-1:0] valid;

  logic [cel_pkg::SLOT_W-1:0] next_slot_next;
  logic [cel_pkg::SLOT_W-1:0] oldest_slot_next;
  logic                       full_flag_next;
  logic [cel_pkg::SIZE_W-1:0] n;
  logic [cel_pkg::SIZE_W-1:0] slot_inc;
  logic                       wrap;
  logic [cel_pkg::SUM_W-1:0]  pos_sum;
  logic [cel_pkg::SUM_W-1:0]  pos_wrap;
  logic [cel_pkg::SLOT_W-1:0] rd_slot;
  logic                       idx_ok;
  logic                       do_write;
  logic                       do_read;
  logic                       do_clear;

  assign n        = cel_pkg::ring_size(entries_in_use);
  assign do_write = accept && (kind == cel_pkg::KIND_WRITE);
  assign do_read  = accept && (kind == cel_pkg::KIND_READ);
  assign do_clear = accept && (kind == cel_pkg::KIND_CLEAR);

  // Write pointer advance with wrap at the ring size.
  assign slot_inc = cel_pkg::SIZE_W'(next_slot) + cel_pkg::SIZE_W'(1);
  assign wrap     = (slot_inc >= n);

  always_comb begin
    next_slot_next   = next_slot;
    oldest_slot_next = oldest_slot;
    full_flag_next   = full_flag;
    if (do_write) begin
      next_slot_next = wrap ? '0 : cel_pkg::SLOT_W'(slot_inc);
      full_flag_next = full_flag || wrap;
      if (full_flag_next) begin
        oldest_slot_next = next_slot_next;
      end
    end
  end

  // Read position counted from the oldest entry, wrapped once.
  assign idx_ok   = (cel_pkg::SUM_W'(read_index) < cel_pkg::SUM_W'(n));
  assign pos_sum  = cel_pkg::SUM_W'(oldest_slot) + cel_pkg::SUM_W'(read_index);
  assign pos_wrap = (pos_sum >= cel_pkg::SUM_W'(n)) ? (pos_sum - cel_pkg::SUM_W'(n))
                                                    : pos_sum;
  assign rd_slot  = cel_pkg::SLOT_W'(pos_wrap);

  // Memory port: writes go to the write pointer, reads to the wrapped position.
  assign mem_we   = do_write;
  assign mem_addr = do_write ? next_slot : rd_slot;

  // Ring state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= cel_pkg::CFG_RESET;
      next_slot      <= '0;
      oldest_slot    <= '0;
      full_flag      <= 1'b0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
      next_slot      <= '0;
      oldest_slot    <= '0;
      full_flag      <= 1'b0;
    end else if (do_clear) begin
      next_slot      <= '0;
      oldest_slot    <= '0;
      full_flag      <= 1'b0;
    end else begin
      next_slot      <= next_slot_next;
      oldest_slot    <= oldest_slot_next;
      full_flag      <= full_flag_next;
    end
  end

  // Slot valid bits stand in for zeroing the store on reset and clear.
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      valid <= '0;
    end else if (do_write) begin
      valid[next_slot] <= 1'b1;
    end
  end

  // Read status, aligned with the registered memory output.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_info <= '0;
    end else begin
      rd_info.strobe <= do_read;
      rd_info.err    <= !idx_ok;
      rd_info.full   <= full_flag;
      rd_info.hit    <= idx_ok && valid[rd_slot];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/circular_event_log_unit.sv
// A read result appears with strobe in the cycle after its command is taken.
// Throughput: one command per cycle, set by the single-port log memory.
// Writes, clears and unused codes give no result; busy never rises.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Synchronous reset empties the ring at once through per-slot valid bits.
// ----------------------------------------------------------------------------
// Circular event log unit
// Ring of log entries that overwrites the oldest entry once it has wrapped.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_event_log_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cel_pkg::KIND_W-1:0]    kind,
  input  wire logic [cel_pkg::CYCLE_W-1:0]   cycle_number,
  input  wire logic [cel_pkg::TIME_W-1:0]    log_time,
  input  wire logic [cel_pkg::CODE_W-1:0]    error_code,
  input  wire logic [cel_pkg::IDX_W-1:0]     read_index,
  input  wire logic                          entries_we,
  input  wire logic [cel_pkg::CFG_W-1:0]     entries_wdata,
  output logic                               strobe,
  output logic      [cel_pkg::CYCLE_W-1:0]   out_cycle_number,
  output logic      [cel_pkg::TIME_W-1:0]    out_time,
  output logic      [cel_pkg::CODE_W-1:0]    out_error_code,
  output logic                               index_error,
  output logic                               ring_full
);

  logic                          accept;
  logic                          mem_we;
  logic [cel_pkg::SLOT_W-1:0]    mem_addr;
  logic [cel_pkg::ENTRY_W-1:0]   mem_wdata;
  logic [cel_pkg::ENTRY_W-1:0]   mem_rdata;
  logic [cel_pkg::ENTRY_W-1:0]   entry;
  cel_pkg::rd_info_t             rd_info;
  logic                          full_flag;

  // Every command is accepted in the cycle it is issued.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign mem_wdata = {cycle_number, log_time, error_code};

  cel_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .read_index (read_index),
    .cfg_we     (entries_we),
    .cfg_wdata  (entries_wdata),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .rd_info    (rd_info),
    .full_flag  (full_flag)
  );

  cel_ram #(
    .WIDTH (cel_pkg::ENTRY_W),
    .DEPTH (cel_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Slots never written since reset or clear, and bad indexes, read as zero.
  assign entry = rd_info.hit ? mem_rdata : '0;

  assign strobe           = rd_info.strobe;
  assign out_cycle_number = entry[cel_pkg::ENTRY_W-1 -: cel_pkg::CYCLE_W];
  assign out_time         = entry[cel_pkg::CODE_W +: cel_pkg::TIME_W];
  assign out_error_code   = entry[cel_pkg::CODE_W-1:0];
  assign index_error      = rd_info.err;
  assign ring_full        = rd_info.full;

  // A read transfer yields a result in the next cycle.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == cel_pkg::KIND_READ)) |=> strobe)
    else $error("read command gave no result");

  // No result appears without a read in the cycle before.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accept && (kind == cel_pkg::KIND_READ)))
    else $error("result without read command");

  // A bad index returns zero data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && index_error) |->
      (out_cycle_number == '0 && out_time == '0 && out_error_code == '0))
    else $error("index error with nonzero data");

  // A clear drops the full flag.
  a_clear_full: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == cel_pkg::KIND_CLEAR)) |=> !full_flag)
    else $error("full flag survived a clear");

endmodule

`default_nettype wire
